>>> rtl/random_pick_key_set_unit_defines.svh
// Assertion macros for the random pick key set unit.
// Needs a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef RANDOM_PICK_KEY_SET_UNIT_DEFINES_SVH
`define RANDOM_PICK_KEY_SET_UNIT_DEFINES_SVH

// The condition implies the consequence in the same cycle.
`define RPKS_ASSERT_SAME(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("rpks assertion failed");

// The condition implies the consequence in the next cycle.
`define RPKS_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("rpks assertion failed");

`endif

>>> rtl/rpks_pkg.sv
// Package for the random pick key set unit: sizes, mode and status codes.
// Has no dependencies.
`timescale 1ns / 1ps

package rpks_pkg;

    localparam int CAPACITY   = 64;
    localparam int KEY_BITS   = 32;
    localparam int SLOT_BITS  = $clog2(CAPACITY);
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    localparam int IDX_BITS   = 6;
    localparam int CMP_BITS   = (COUNT_BITS > IDX_BITS) ? COUNT_BITS : IDX_BITS;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_PICK   = 2'd2;

    localparam logic [2:0] STATUS_DONE      = 3'd0;
    localparam logic [2:0] STATUS_DUPLICATE = 3'd1;
    localparam logic [2:0] STATUS_NOT_FOUND = 3'd2;
    localparam logic [2:0] STATUS_RANGE     = 3'd3;
    localparam logic [2:0] STATUS_FULL      = 3'd4;

endpackage

>>> rtl/random_pick_key_set_unit.sv
// Random pick key set unit: a dense set of distinct keys in one key memory.
// Throughput: one beat in flight; the search reads one slot per cycle through
// the single read port of the key memory.
// Reset clears the key count and the control state; the key memory is not cleared.
// Depends on rpks_pkg and random_pick_key_set_unit_defines.svh.
`timescale 1ns / 1ps
`include "random_pick_key_set_unit_defines.svh"

module random_pick_key_set_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [31:0] key,
    input  logic [5:0]  pick_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] picked_key,
    output logic [2:0]  status,
    output logic [6:0]  key_count
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_MOVE = 3'd2;
    localparam logic [2:0] ST_PICK = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam int SB = rpks_pkg::SLOT_BITS;
    localparam int CB = rpks_pkg::COUNT_BITS;
    localparam int KB = rpks_pkg::KEY_BITS;

    logic [2:0]    state_reg, state_next;
    logic [1:0]    mode_reg, mode_next;
    logic [KB-1:0] key_reg, key_next;
    logic [CB-1:0] count_reg, count_next;
    logic [CB-1:0] iss_reg, iss_next;
    logic [SB-1:0] slot_reg, slot_next;
    logic          rd_valid_reg;
    logic [SB-1:0] rd_slot_reg;
    logic [31:0]   res_key_reg, res_key_next;
    logic [2:0]    res_status_reg, res_status_next;
    logic          out_valid_reg, out_valid_next;
    logic [31:0]   out_key_reg;
    logic [2:0]    out_status_reg;
    logic [6:0]    out_count_reg;
    logic          out_load;

    logic [KB-1:0] key_mem [rpks_pkg::CAPACITY];
    logic          rd_en;
    logic [SB-1:0] rd_addr;
    logic [KB-1:0] rd_data_reg;
    logic          wr_en;
    logic [SB-1:0] wr_addr;
    logic [KB-1:0] wr_data;

    logic [CB-1:0] count_m1;
    logic          hit;
    logic          last;
    logic          pick_bad;

    assign count_m1 = CB'(count_reg - 1'b1);
    assign hit      = rd_valid_reg && (rd_data_reg == key_reg);
    assign last     = rd_valid_reg && (rd_slot_reg == count_m1[SB-1:0]);
    assign pick_bad = (rpks_pkg::CMP_BITS'(pick_index) >= rpks_pkg::CMP_BITS'(count_reg));

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign picked_key = out_key_reg;
    assign status     = out_status_reg;
    assign key_count  = out_count_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= key_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        count_next      = count_reg;
        iss_next        = iss_reg;
        slot_next       = slot_reg;
        res_key_next    = res_key_reg;
        res_status_next = res_status_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = key_reg;
        out_load        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next       = mode;
                    key_next        = KB'(key);
                    res_key_next    = '0;
                    res_status_next = rpks_pkg::STATUS_DONE;
                    state_next      = ST_DONE;
                    case (mode)
                        rpks_pkg::MODE_INSERT,
                        rpks_pkg::MODE_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                if (mode == rpks_pkg::MODE_INSERT)
                                begin
                                    wr_en      = 1'b1;
                                    wr_data    = KB'(key);
                                    count_next = CB'(1);
                                end
                                else
                                begin
                                    res_status_next = rpks_pkg::STATUS_NOT_FOUND;
                                end
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                iss_next   = CB'(1);
                                state_next = ST_SCAN;
                            end
                        end
                        rpks_pkg::MODE_PICK:
                        begin
                            if (pick_bad)
                            begin
                                res_status_next = rpks_pkg::STATUS_RANGE;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = SB'(pick_index);
                                state_next = ST_PICK;
                            end
                        end
                        default:
                        begin
                            res_status_next = rpks_pkg::STATUS_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    if (mode_reg == rpks_pkg::MODE_INSERT)
                    begin
                        res_status_next = rpks_pkg::STATUS_DUPLICATE;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        // Fetch the last held key to fill the freed slot.
                        rd_en      = 1'b1;
                        rd_addr    = count_m1[SB-1:0];
                        slot_next  = rd_slot_reg;
                        state_next = ST_MOVE;
                    end
                end
                else if (last)
                begin
                    state_next = ST_DONE;
                    if (mode_reg == rpks_pkg::MODE_INSERT)
                    begin
                        if (count_reg == CB'(rpks_pkg::CAPACITY))
                        begin
                            res_status_next = rpks_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[SB-1:0];
                            count_next = CB'(count_reg + 1'b1);
                        end
                    end
                    else
                    begin
                        res_status_next = rpks_pkg::STATUS_NOT_FOUND;
                    end
                end
                else if (iss_reg < count_reg)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = iss_reg[SB-1:0];
                    iss_next = CB'(iss_reg + 1'b1);
                end
            end
            ST_MOVE:
            begin
                wr_en      = 1'b1;
                wr_addr    = slot_reg;
                wr_data    = rd_data_reg;
                count_next = count_m1;
                state_next = ST_DONE;
            end
            ST_PICK:
            begin
                res_key_next = 32'(rd_data_reg);
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_valid_reg  <= rd_en;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        key_reg        <= key_next;
        iss_reg        <= iss_next;
        slot_reg       <= slot_next;
        rd_slot_reg    <= rd_addr;
        res_key_reg    <= res_key_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            out_key_reg    <= res_key_reg;
            out_status_reg <= res_status_reg;
            out_count_reg  <= 7'(count_reg);
        end
    end

    `RPKS_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CB'(rpks_pkg::CAPACITY))
    `RPKS_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_reg != ST_IDLE)
    `RPKS_ASSERT_SAME(a_write_states, wr_en, (state_reg == ST_IDLE) || (state_reg == ST_SCAN) || (state_reg == ST_MOVE))
    `RPKS_ASSERT_NEXT(a_done_loads, (state_reg == ST_DONE) && !out_valid_reg, out_valid_reg && (state_reg == ST_IDLE))

endmodule
